// ===== rtl/cdq_pkg.sv =====
package cdq_pkg;

   // widths of the item fields
   localparam int unsigned OP_WIDTH     = 3;
   localparam int unsigned VALUE_WIDTH  = 32;
   localparam int unsigned STATUS_WIDTH = 2;

   // packed stream widths, rounded up to whole bytes
   localparam int unsigned REQ_DATA_WIDTH = 40;
   localparam int unsigned RSP_DATA_WIDTH = 40;

   // operation codes carried by a request
   typedef enum logic [OP_WIDTH-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_REAR  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_REAR  = 3'd5
   } op_type;

   // status codes carried by a response
   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // what every cell of one lane does in a cycle
   typedef enum logic [2:0] {
      LANE_HOLD,
      LANE_SHIFT_IN,
      LANE_SHIFT_OUT,
      LANE_APPEND,
      LANE_DROP
   } lane_op_type;

   typedef struct packed {
      lane_op_type             op;
      logic [VALUE_WIDTH-1:0]  value;
   } lane_cmd_type;

endpackage

// ===== rtl/cdq_cell.sv =====
module cdq_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  cdq_pkg::lane_cmd_type             cmd,
   input  logic [cdq_pkg::VALUE_WIDTH-1:0]   left_data,
   input  logic                              left_valid,
   input  logic [cdq_pkg::VALUE_WIDTH-1:0]   right_data,
   input  logic                              right_valid,
   output logic [cdq_pkg::VALUE_WIDTH-1:0]   data,
   output logic                              valid
);
   import cdq_pkg::*;

   logic [VALUE_WIDTH-1:0] data_ff;
   logic [VALUE_WIDTH-1:0] data_in;
   logic                   valid_ff;
   logic                   valid_in;

   // next slot contents from the lane command and the two neighbors
   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      unique case (cmd.op)
         LANE_SHIFT_IN: begin
            data_in  = left_data;
            valid_in = left_valid;
         end
         LANE_SHIFT_OUT: begin
            data_in  = right_data;
            valid_in = right_valid;
         end
         LANE_APPEND: begin
            // first free slot after the occupied run
            if (!valid_ff && left_valid) begin
               data_in  = cmd.value;
               valid_in = 1'b1;
            end
         end
         LANE_DROP: begin
            // last occupied slot of the run
            if (valid_ff && !right_valid) begin
               valid_in = 1'b0;
            end
         end
         default: begin
            data_in  = data_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   // occupancy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // slot payload
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign valid = valid_ff;

endmodule

// ===== rtl/cdq_chain.sv =====
module cdq_chain #(
   parameter int unsigned DEPTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cdq_pkg::lane_cmd_type             cmd,
   output logic [cdq_pkg::VALUE_WIDTH-1:0]   head_data,
   output logic                              head_valid,
   output logic                              tail_valid
);
   import cdq_pkg::*;

   logic [VALUE_WIDTH-1:0] cell_data  [DEPTH];
   logic                   cell_valid [DEPTH];

   // row of cells, cell 0 holds the element at the head of this lane
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] left_data;
      logic                   left_valid;
      logic [VALUE_WIDTH-1:0] right_data;
      logic                   right_valid;

      if (i == 0) begin : g_first
         assign left_data  = cmd.value;
         assign left_valid = 1'b1;
      end else begin : g_inner_left
         assign left_data  = cell_data[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data  = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner_right
         assign right_data  = cell_data[i+1];
         assign right_valid = cell_valid[i+1];
      end

      cdq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_data   (left_data),
         .left_valid  (left_valid),
         .right_data  (right_data),
         .right_valid (right_valid),
         .data        (cell_data[i]),
         .valid       (cell_valid[i])
      );
   end

   assign head_data  = cell_data[0];
   assign head_valid = cell_valid[0];
   assign tail_valid = cell_valid[DEPTH-1];

endmodule

// ===== rtl/circular_deque_top.sv =====
// Double-ended queue of signed 32-bit values, DEPTH entries deep.
// Request channel (req_): one transaction per operation, tdata carries the
// operation code and the value to push. Response channel (rsp_): exactly one
// transaction per request, carrying the value read and a status (ok, full on
// a refused push, empty on a refused pop or peek).
// Storage is two rows of DEPTH cells. One row keeps the elements in order
// from the front, the other in order from the rear, so both ends are always
// read at cell 0 of a row; pushes and pops shift a row by one cell or load or
// clear the cell at the end of its occupied run, both rows together.
// The response is registered and appears in the cycle after the request is accepted.
// Throughput: one operation per cycle while the response side keeps up.
// A finished response waits in the output register; a new request is taken
// in the same cycle the waiting response is taken, so a stalled receiver
// holds the request side after one pending response.
// Reset (synchronous) empties the deque and drops any pending response; no
// clearing pass is needed and requests are accepted right after reset.
module circular_deque_top #(
   parameter int unsigned DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request: [2:0] operation, [34:3] push_value, [39:35] zero
   input  logic [cdq_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // response: [31:0] read_value, [33:32] status, [39:34] zero
   output logic [cdq_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready
);
   import cdq_pkg::*;

   logic                   accept;
   op_type                 op_code;
   logic [VALUE_WIDTH-1:0] push_value;
   lane_cmd_type           front_cmd;
   lane_cmd_type           rear_cmd;
   logic [VALUE_WIDTH-1:0] front_head;
   logic [VALUE_WIDTH-1:0] rear_head;
   logic                   front_head_valid;
   logic                   rear_head_valid;
   logic                   front_full;
   logic                   rear_full;
   logic                   is_empty;
   logic                   is_full;
   logic [VALUE_WIDTH-1:0] read_value;
   status_type             status;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_in;

   // request decode
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign op_code    = op_type'(req_tdata[OP_WIDTH-1:0]);
   assign push_value = req_tdata[OP_WIDTH +: VALUE_WIDTH];
   assign is_empty   = !front_head_valid;
   assign is_full    = front_full;

   // lane commands and the response of the current request
   always_comb begin
      front_cmd.op    = LANE_HOLD;
      front_cmd.value = push_value;
      rear_cmd.op     = LANE_HOLD;
      rear_cmd.value  = push_value;
      read_value      = '0;
      status          = ST_OK;
      unique case (op_code)
         OP_PUSH_FRONT: begin
            if (is_full) begin
               status = ST_FULL;
            end else begin
               front_cmd.op = LANE_SHIFT_IN;
               rear_cmd.op  = LANE_APPEND;
            end
         end
         OP_PUSH_REAR: begin
            if (is_full) begin
               status = ST_FULL;
            end else begin
               front_cmd.op = LANE_APPEND;
               rear_cmd.op  = LANE_SHIFT_IN;
            end
         end
         OP_POP_FRONT: begin
            if (is_empty) begin
               status = ST_EMPTY;
            end else begin
               read_value   = front_head;
               front_cmd.op = LANE_SHIFT_OUT;
               rear_cmd.op  = LANE_DROP;
            end
         end
         OP_POP_REAR: begin
            if (is_empty) begin
               status = ST_EMPTY;
            end else begin
               read_value   = rear_head;
               front_cmd.op = LANE_DROP;
               rear_cmd.op  = LANE_SHIFT_OUT;
            end
         end
         OP_PEEK_FRONT: begin
            if (is_empty) begin
               status = ST_EMPTY;
            end else begin
               read_value = front_head;
            end
         end
         OP_PEEK_REAR: begin
            if (is_empty) begin
               status = ST_EMPTY;
            end else begin
               read_value = rear_head;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
      if (!accept) begin
         front_cmd.op = LANE_HOLD;
         rear_cmd.op  = LANE_HOLD;
      end
   end

   // element row ordered from the front
   cdq_chain #(
      .DEPTH (DEPTH)
   ) u_front_chain (
      .clock      (clock),
      .reset      (reset),
      .cmd        (front_cmd),
      .head_data  (front_head),
      .head_valid (front_head_valid),
      .tail_valid (front_full)
   );

   // element row ordered from the rear
   cdq_chain #(
      .DEPTH (DEPTH)
   ) u_rear_chain (
      .clock      (clock),
      .reset      (reset),
      .cmd        (rear_cmd),
      .head_data  (rear_head),
      .head_valid (rear_head_valid),
      .tail_valid (rear_full)
   );

   // response output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_DATA_WIDTH - VALUE_WIDTH - STATUS_WIDTH){1'b0}},
                         status, read_value};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // both rows always hold the same number of elements; checked as agreement on empty and on full
   a_rows_agree_empty: assert property (@(posedge clock) disable iff (reset)
      front_head_valid == rear_head_valid)
      else $error("front and rear rows disagree on empty");

   a_rows_agree_full: assert property (@(posedge clock) disable iff (reset)
      front_full == rear_full)
      else $error("front and rear rows disagree on full");

   // a push into an empty deque leaves one element seen from both ends
   a_single_push: assert property (@(posedge clock) disable iff (reset)
      accept && is_empty && (op_code == OP_PUSH_FRONT || op_code == OP_PUSH_REAR)
      |=> front_head_valid && front_head == rear_head)
      else $error("single element differs between the two ends");

   // every accepted request produces a pending response
   a_response_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request without response");

   // refused operations return no data
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[VALUE_WIDTH +: STATUS_WIDTH] != ST_OK
      |-> rsp_data_ff[VALUE_WIDTH-1:0] == '0)
      else $error("refused operation returned data");

endmodule

// ===== tb/sv/circular_deque_top_tb.sv =====
module circular_deque_top_tb;
   import cdq_pkg::*;

   localparam int unsigned DEPTH = 8;
   localparam int unsigned RANDOM_ITEMS = 500;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned DRAIN_CYCLES = 4;

   // operation codes the block ignores
   localparam logic [OP_WIDTH-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_WIDTH-1:0] OP_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] read_value;
      status_type             status;
   } deque_result_type;

   typedef struct {
      logic [OP_WIDTH-1:0]    op;
      logic [VALUE_WIDTH-1:0] value;
      bit                     fixed;
      deque_result_type       result;
   } deque_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   // request: [2:0] operation, [34:3] push_value, [39:35] zero
   logic [REQ_DATA_WIDTH-1:0]   req_tdata = '0;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   // response: [31:0] read_value, [33:32] status, [39:34] zero
   logic [RSP_DATA_WIDTH-1:0]   rsp_tdata;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;

   int unsigned req_idle_pct = 38;
   int unsigned rsp_idle_pct = 79;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   deque_result_type pending_results [$];

   // shadow copy of the deque contents
   logic [VALUE_WIDTH-1:0] shadow_slots [DEPTH];
   int unsigned            shadow_front = 0;
   int unsigned            shadow_rear = 0;
   bit                     shadow_empty = 1'b1;

   // directed rows: fixed rows carry the result typed in, the rest are predicted
   deque_row_type directed_rows [25] = '{
      '{OP_PEEK_FRONT, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_EMPTY}},
      '{OP_POP_REAR,   32'hffff_ffff, 1'b1, '{32'h0000_0000, ST_EMPTY}},
      '{OP_SPARE_6,    32'h1234_5678, 1'b1, '{32'h0000_0000, ST_OK}},
      '{OP_SPARE_7,    32'hffff_ffff, 1'b1, '{32'h0000_0000, ST_OK}},
      '{OP_PUSH_REAR,  32'h7fff_ffff, 1'b1, '{32'h0000_0000, ST_OK}},
      '{OP_PEEK_FRONT, 32'h0000_0000, 1'b1, '{32'h7fff_ffff, ST_OK}},
      '{OP_PUSH_FRONT, 32'h8000_0000, 1'b1, '{32'h0000_0000, ST_OK}},
      '{OP_PEEK_FRONT, 32'h0000_0000, 1'b1, '{32'h8000_0000, ST_OK}},
      '{OP_PEEK_REAR,  32'h0000_0000, 1'b1, '{32'h7fff_ffff, ST_OK}},
      '{OP_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h8000_0000, ST_OK}},
      '{OP_POP_REAR,   32'h0000_0000, 1'b1, '{32'h7fff_ffff, ST_OK}},
      '{OP_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0000_0000, ST_EMPTY}},
      '{OP_PUSH_REAR,  32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK}},
      '{OP_PUSH_REAR,  32'h0000_0001, 1'b1, '{32'h0000_0000, ST_OK}},
      '{OP_PUSH_REAR,  32'h0000_0002, 1'b1, '{32'h0000_0000, ST_OK}},
      '{OP_PUSH_REAR,  32'h0000_0003, 1'b1, '{32'h0000_0000, ST_OK}},
      '{OP_PUSH_REAR,  32'h0000_0004, 1'b1, '{32'h0000_0000, ST_OK}},
      '{OP_PUSH_REAR,  32'h0000_0005, 1'b1, '{32'h0000_0000, ST_OK}},
      '{OP_PUSH_REAR,  32'h0000_0006, 1'b1, '{32'h0000_0000, ST_OK}},
      '{OP_PUSH_REAR,  32'h0000_0007, 1'b1, '{32'h0000_0000, ST_OK}},
      '{OP_PUSH_FRONT, 32'h5555_5555, 1'b1, '{32'h0000_0000, ST_FULL}},
      '{OP_PUSH_REAR,  32'haaaa_aaaa, 1'b1, '{32'h0000_0000, ST_FULL}},
      '{OP_POP_REAR,   32'h0000_0000, 1'b1, '{32'h0000_0007, ST_OK}},
      '{OP_PUSH_FRONT, 32'hffff_ffff, 1'b0, '{32'h0000_0000, ST_OK}},
      '{OP_PEEK_FRONT, 32'h0000_0000, 1'b0, '{32'h0000_0000, ST_OK}}
   };

   circular_deque_top #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // circular index moves
   function automatic int unsigned index_up(int unsigned i);
      return (i == DEPTH - 1) ? 0 : i + 1;
   endfunction

   function automatic int unsigned index_down(int unsigned i);
      return (i == 0) ? DEPTH - 1 : i - 1;
   endfunction

   // apply one operation to the shadow deque and return its result
   function automatic deque_result_type apply_deque_op(logic [OP_WIDTH-1:0] op,
                                                       logic [VALUE_WIDTH-1:0] value);
      deque_result_type res;
      res.read_value = '0;
      res.status = ST_OK;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_REAR: begin
            if (!shadow_empty && index_up(shadow_rear) == shadow_front) begin
               res.status = ST_FULL;
            end else if (shadow_empty) begin
               shadow_front = 0;
               shadow_rear = 0;
               shadow_empty = 1'b0;
               shadow_slots[0] = value;
            end else if (op == OP_PUSH_FRONT) begin
               shadow_front = index_down(shadow_front);
               shadow_slots[shadow_front] = value;
            end else begin
               shadow_rear = index_up(shadow_rear);
               shadow_slots[shadow_rear] = value;
            end
         end
         OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR: begin
            if (shadow_empty) begin
               res.status = ST_EMPTY;
            end else begin
               res.read_value = (op == OP_POP_REAR || op == OP_PEEK_REAR) ?
                                shadow_slots[shadow_rear] : shadow_slots[shadow_front];
               if (op == OP_POP_FRONT || op == OP_POP_REAR) begin
                  // last element leaves: back to the reset picture
                  if (shadow_front == shadow_rear) begin
                     shadow_empty = 1'b1;
                     shadow_front = 0;
                     shadow_rear = 0;
                  end else if (op == OP_POP_FRONT) begin
                     shadow_front = index_up(shadow_front);
                  end else begin
                     shadow_rear = index_down(shadow_rear);
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [VALUE_WIDTH-1:0] got,
                                  input logic [VALUE_WIDTH-1:0] want);
      $display("mismatch: %s got %h expected %h", what, got, want);
      mismatch_count++;
   endtask

   // drive one request transaction and record what it should return
   task automatic send_request(input logic [OP_WIDTH-1:0] op,
                               input logic [VALUE_WIDTH-1:0] value,
                               input bit fixed, input deque_result_type fixed_result);
      deque_result_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_WIDTH'({value, op});
      do @(posedge clock); while (!req_tready);
      predicted = apply_deque_op(op, value);
      pending_results.push_back(fixed ? fixed_result : predicted);
   endtask

   // random traffic that swings between filling and draining
   task automatic run_random(input int unsigned count);
      int unsigned push_pct;
      logic [OP_WIDTH-1:0] op;
      logic [VALUE_WIDTH-1:0] value;
      deque_result_type unused;
      push_pct = 50;
      unused = '0;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 16 == 0) begin
            case ($urandom_range(2))
               0: push_pct = 85;
               1: push_pct = 50;
               default: push_pct = 15;
            endcase
         end
         if ($urandom_range(49) == 0) begin
            op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
         end else if ($urandom_range(99) < push_pct) begin
            op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
         end else begin
            case ($urandom_range(3))
               0: op = OP_POP_FRONT;
               1: op = OP_POP_REAR;
               2: op = OP_PEEK_FRONT;
               default: op = OP_PEEK_REAR;
            endcase
         end
         case ($urandom_range(11))
            0: value = 32'h7fff_ffff;
            1: value = 32'h8000_0000;
            2: value = 32'h0000_0000;
            3: value = 32'hffff_ffff;
            default: value = $urandom;
         endcase
         send_request(op, value, 1'b0, unused);
      end
   endtask

   // receiver stalls
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // response check against the oldest expectation
   always @(posedge clock) begin : rsp_check
      deque_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response with nothing pending", rsp_tdata[VALUE_WIDTH-1:0], '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[VALUE_WIDTH-1:0] !== want.read_value)
               report_mismatch("read_value", rsp_tdata[VALUE_WIDTH-1:0], want.read_value);
            if (rsp_tdata[VALUE_WIDTH +: STATUS_WIDTH] !== want.status)
               report_mismatch("status", VALUE_WIDTH'(rsp_tdata[VALUE_WIDTH +: STATUS_WIDTH]),
                               VALUE_WIDTH'(want.status));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].op, directed_rows[i].value,
                      directed_rows[i].fixed, directed_rows[i].result);
      end

      // random phases: slow receiver, then slow sender, then full rate
      run_random(RANDOM_ITEMS / 3);
      req_idle_pct = 79;
      rsp_idle_pct = 38;
      run_random(RANDOM_ITEMS / 3);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
      req_tvalid <= 1'b0;

      // drain
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/cdq_pkg.sv
rtl/cdq_cell.sv
rtl/cdq_chain.sv
rtl/circular_deque_top.sv
tb/sv/circular_deque_top_tb.sv
